// ----- sv/spq_pkg.sv -----
// Package for the sorted priority queue: payload structs, operation and
// status codes, and the cell control struct. No dependencies.
`default_nettype none

package spq_pkg;

  localparam int DATA_W        = 32;
  localparam int PRIO_W        = 16;
  localparam int ENTRY_COUNT_W = 5;
  localparam int STATUS_W      = 2;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_PUSH_FULL  = 2'd1,
    STATUS_POP_EMPTY  = 2'd2
  } status_t;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] item_data;
    logic [PRIO_W-1:0]        item_priority;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  head_data;
    logic                      queue_empty;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0]       status;
  } rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
  } entry_t;

  typedef struct packed {
    logic shift_in;
    logic shift_out;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/spq_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
// Payload types come from spq_pkg.
`default_nettype none

interface spq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/spq_cell.sv -----
// One slot of the sorted queue: holds an entry and shifts toward either
// neighbor on insert or head removal. Uses spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               left_keep,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire spq_pkg::entry_t    right_entry,
  input  wire spq_pkg::entry_t    new_entry,
  output spq_pkg::entry_t         entry,
  output logic                    keep
);

  spq_pkg::entry_t entry_next;

  // Sorted order makes the kept cells a prefix; ties stay ahead of the new one.
  assign keep = occupied && (entry.prio <= new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.shift_in && !keep) begin
      entry_next = left_keep ? new_entry : left_entry;
    end else if (ctrl.shift_out) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ----- sv/sorted_priority_queue_top.sv -----
// Channel  Dir  Payload                                          Transfer
// req      in   func, item_data, item_priority                   valid & ready
// rsp      out  head_data, queue_empty, entry_count, status      valid & ready
//
// One item per cycle while rsp is not stalled: every cell compares against the
// pushed priority in parallel and the whole row shifts in that same cycle.
// The result appears in the cycle after the transfer and is held until taken;
// req stays ready while rsp is empty or being taken in the same cycle.
// Reset clears the fill count and the result valid; slot contents need none.
// Depends on spq_pkg, spq_stream_if and spq_cell.
`default_nettype none

module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  spq_stream_if.sink   req,
  spq_stream_if.source rsp
);

  localparam int CountW = $clog2(QUEUE_DEPTH + 1);

  logic [CountW-1:0]   count;
  logic [CountW-1:0]   count_next;
  logic                rsp_valid;
  spq_pkg::status_t    status;
  spq_pkg::status_t    status_next;
  logic                accept;
  logic                full;
  logic                empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     entries [QUEUE_DEPTH];
  logic                keeps   [QUEUE_DEPTH];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CountW'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  assign new_entry.data = req.payload.item_data;
  assign new_entry.prio = req.payload.item_priority;

  always_comb begin
    ctrl        = '0;
    count_next  = count;
    status_next = spq_pkg::STATUS_OK;
    if (req.payload.func == spq_pkg::FUNC_PUSH) begin
      if (full) begin
        status_next = spq_pkg::STATUS_PUSH_FULL;
      end else begin
        ctrl.shift_in = accept;
        count_next    = count + CountW'(1);
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::STATUS_POP_EMPTY;
      end else begin
        ctrl.shift_out = accept;
        count_next     = count - CountW'(1);
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_keep;

    if (i == 0) begin : g_first
      assign left_entry = new_entry;
      assign left_keep  = 1'b1;
    end else begin : g_rest
      assign left_entry = entries[i-1];
      assign left_keep  = keeps[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (count > CountW'(i)),
      .left_keep   (left_keep),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .new_entry   (new_entry),
      .entry       (entries[i]),
      .keep        (keeps[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
      status    <= spq_pkg::STATUS_OK;
    end else begin
      if (accept) begin
        count     <= count_next;
        status    <= status_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // State only changes together with a new result, so it reads out directly.
  assign rsp.valid               = rsp_valid;
  assign rsp.payload.head_data   = empty ? '0 : entries[0].data;
  assign rsp.payload.queue_empty = empty;
  assign rsp.payload.entry_count = spq_pkg::ENTRY_COUNT_W'(count);
  assign rsp.payload.status      = status;

endmodule

`default_nettype wire
